[hw/rtl/sat_pkg.sv]
// Shared types, codes and defaults for the scope aware tokenizer.
package sat_pkg;

   localparam int DEFAULT_MAX_DELIMS      = 8;
   localparam int DEFAULT_MAX_SCOPE_CHARS = 4;
   localparam int DEFAULT_DEPTH_BITS      = 8;

   localparam int DELIM_SET_BITS = 64;
   localparam int SCOPE_SET_BITS = 32;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [DELIM_SET_BITS-1:0] DELIM_SET_RESET = 64'd32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DELIMITER_SET   = 2'd0,
      CSR_OPEN_SCOPE_SET  = 2'd1,
      CSR_CLOSE_SCOPE_SET = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_SKIP  = 2'd0,
      KIND_TOKEN = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_NONE  = 2'd0,
      STATUS_CLEAN = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   typedef struct packed {
      logic is_delim;
      logic is_open;
      logic is_close;
   } match_type;

endpackage

[hw/rtl/sat_match.sv]
// Character set lookup: compares one byte against the packed slots of a set.
module sat_match #(
   parameter int SLOTS    = 8,
   parameter int SET_BITS = 64
) (
   input  logic [SET_BITS-1:0] set_bits,
   input  logic [7:0]          byte_in,
   output logic                hit
);
   import sat_pkg::*;

   localparam int USED = (SLOTS < SET_BITS / 8) ? SLOTS : SET_BITS / 8;

   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < USED; i++) begin
         if (set_bits[8*i +: 8] != 8'd0 && set_bits[8*i +: 8] == byte_in) begin
            hit = 1'b1;
         end
      end
   end

endmodule

[hw/rtl/sat_step.sv]
// Per-item classification and next string state (phase, depth, error).
module sat_step #(
   parameter int DEPTH_BITS = 8
) (
   input  sat_pkg::match_type     match,
   input  logic                   last_byte,
   input  logic                   in_token,
   input  logic [DEPTH_BITS-1:0]  nest_depth,
   input  logic                   error_latched,
   output sat_pkg::kind_type      kind,
   output sat_pkg::status_type    status,
   output logic                   error_now,
   output logic                   in_token_next,
   output logic [DEPTH_BITS-1:0]  nest_depth_next,
   output logic                   error_next
);
   import sat_pkg::*;

   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

   always_comb begin
      logic                  tok;
      logic [DEPTH_BITS-1:0] dep;
      logic                  err;
      logic                  ends;
      tok       = in_token;
      dep       = nest_depth;
      err       = error_latched;
      ends      = 1'b0;
      kind      = KIND_SKIP;
      error_now = 1'b0;

      if (!error_latched) begin
         if (!tok && !match.is_delim && dep == '0) begin
            tok = 1'b1;
         end
         if (tok && match.is_delim && dep == '0) begin
            ends = 1'b1;
         end else if (match.is_open) begin
            if (dep != DEPTH_MAX) begin
               dep = dep + DEPTH_BITS'(1);
            end
         end else if (match.is_close) begin
            if (dep == '0) begin
               error_now = 1'b1;
               err       = 1'b1;
            end else begin
               dep = dep - DEPTH_BITS'(1);
            end
         end
         if (error_now) begin
            kind = KIND_SKIP;
         end else if (ends) begin
            kind = KIND_END;
            tok  = 1'b0;
         end else begin
            kind = tok ? KIND_TOKEN : KIND_SKIP;
         end
      end

      status = STATUS_NONE;
      if (last_byte) begin
         status = (err || (!tok && dep != '0)) ? STATUS_ERROR : STATUS_CLEAN;
         tok    = 1'b0;
         dep    = '0;
         err    = 1'b0;
      end

      in_token_next   = tok;
      nest_depth_next = dep;
      error_next      = err;
   end

endmodule

[hw/rtl/scope_aware_tokenizer_top.sv]
// Top level of the scope aware tokenizer: registers, set lookup and result stage.
//
// One byte item is accepted every cycle while req_ready is high. Each item sits in the
// input register and its result is then presented from the result register. The rate
// is set by the per-byte update of the token phase and nesting depth, which is done
// combinationally between the input register and the result register. A stalled
// result stage holds the input register; new items are still taken while the result
// register can drain.
// The user must write character sets through the csr_ port while no item is in flight;
// the block itself does not enforce this.
module scope_aware_tokenizer_top #(
   parameter int MAX_DELIMS      = sat_pkg::DEFAULT_MAX_DELIMS,
   parameter int MAX_SCOPE_CHARS = sat_pkg::DEFAULT_MAX_SCOPE_CHARS,
   parameter int DEPTH_BITS      = sat_pkg::DEFAULT_DEPTH_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [sat_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sat_pkg::DELIM_SET_BITS-1:0]  csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_byte_in,
   input  logic                                req_last_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_byte_out,
   output logic [1:0]                          rsp_byte_kind,
   output logic [1:0]                          rsp_end_status,
   output logic                                rsp_error_now
);
   import sat_pkg::*;

   logic [DELIM_SET_BITS-1:0] delim_set_ff;
   logic [SCOPE_SET_BITS-1:0] open_set_ff;
   logic [SCOPE_SET_BITS-1:0] close_set_ff;

   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;

   logic                  in_token_ff;
   logic [DEPTH_BITS-1:0] nest_depth_ff;
   logic                  error_latched_ff;

   logic                  in_token_in;
   logic [DEPTH_BITS-1:0] nest_depth_in;
   logic                  error_latched_in;

   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_out_ff;
   kind_type   rsp_kind_ff;
   status_type rsp_status_ff;
   logic       rsp_error_now_ff;

   match_type  match;
   kind_type   kind;
   status_type status;
   logic       error_now;
   logic       s2_free;
   logic       advance;

   assign s2_free   = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s2_free;

   sat_match #(.SLOTS(MAX_DELIMS), .SET_BITS(DELIM_SET_BITS)) u_delim (
      .set_bits (delim_set_ff),
      .byte_in  (s1_byte_ff),
      .hit      (match.is_delim)
   );

   sat_match #(.SLOTS(MAX_SCOPE_CHARS), .SET_BITS(SCOPE_SET_BITS)) u_open (
      .set_bits (open_set_ff),
      .byte_in  (s1_byte_ff),
      .hit      (match.is_open)
   );

   sat_match #(.SLOTS(MAX_SCOPE_CHARS), .SET_BITS(SCOPE_SET_BITS)) u_close (
      .set_bits (close_set_ff),
      .byte_in  (s1_byte_ff),
      .hit      (match.is_close)
   );

   sat_step #(.DEPTH_BITS(DEPTH_BITS)) u_step (
      .match           (match),
      .last_byte       (s1_last_ff),
      .in_token        (in_token_ff),
      .nest_depth      (nest_depth_ff),
      .error_latched   (error_latched_ff),
      .kind            (kind),
      .status          (status),
      .error_now       (error_now),
      .in_token_next   (in_token_in),
      .nest_depth_next (nest_depth_in),
      .error_next      (error_latched_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_set_ff <= DELIM_SET_RESET;
         open_set_ff  <= '0;
         close_set_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DELIMITER_SET:   delim_set_ff <= csr_write_data;
            CSR_OPEN_SCOPE_SET:  open_set_ff  <= csr_write_data[SCOPE_SET_BITS-1:0];
            CSR_CLOSE_SCOPE_SET: close_set_ff <= csr_write_data[SCOPE_SET_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         in_token_ff      <= 1'b0;
         nest_depth_ff    <= '0;
         error_latched_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (advance) begin
            in_token_ff      <= in_token_in;
            nest_depth_ff    <= nest_depth_in;
            error_latched_ff <= error_latched_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_byte_in;
         s1_last_ff <= req_last_byte;
      end
      if (advance) begin
         rsp_byte_out_ff  <= s1_byte_ff;
         rsp_kind_ff      <= kind;
         rsp_status_ff    <= status;
         rsp_error_now_ff <= error_now;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_out   = rsp_byte_out_ff;
   assign rsp_byte_kind  = rsp_kind_ff;
   assign rsp_end_status = rsp_status_ff;
   assign rsp_error_now  = rsp_error_now_ff;

   // unmatched close is never reported as part of a token
   a_error_is_skip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_now |-> rsp_byte_kind == KIND_SKIP)
      else $error("unmatched close item not marked skipped");

   // string state returns to idle after the last byte
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && s1_last_ff |=> !in_token_ff && nest_depth_ff == '0 && !error_latched_ff)
      else $error("string state not cleared after last item");

   // once latched, an error freezes the depth until the string ends
   a_error_freezes: assert property (@(posedge clock) disable iff (reset)
      advance && error_latched_ff && !s1_last_ff |=> error_latched_ff && $stable(nest_depth_ff))
      else $error("state changed after error");

   // the last byte always carries an end status
   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      advance && s1_last_ff |=> rsp_valid && rsp_end_status != STATUS_NONE)
      else $error("last item without end status");

endmodule

[dv/scope_aware_tokenizer_top_test.sv]
// Self-checking testbench for scope_aware_tokenizer_top: directed strings, then random traffic.
`timescale 1ns / 100ps
module scope_aware_tokenizer_top_test;
   import sat_pkg::*;

   localparam int DEPTH_LIMIT = (1 << DEFAULT_DEPTH_BITS) - 1;

   typedef struct packed {
      logic [7:0] ch;
      kind_type   kind;
      status_type status;
      logic       err;
   } byte_verdict_type;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_SPARSE, STALL_PATTERN} stall_mode_type;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index        = '0;
   logic [DELIM_SET_BITS-1:0] csr_write_data   = '0;
   logic                      req_valid        = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_byte_in      = 8'h00;
   logic                      req_last_byte    = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready        = 1'b0;
   logic [7:0]                rsp_byte_out;
   logic [1:0]                rsp_byte_kind;
   logic [1:0]                rsp_end_status;
   logic                      rsp_error_now;

   // predictor copy of the character sets and the per-string state
   logic [63:0] delim_chars = DELIM_SET_RESET;
   logic [31:0] open_chars  = '0;
   logic [31:0] close_chars = '0;
   bit          in_tok        = 1'b0;
   int          scope_depth   = 0;
   bit          string_failed = 1'b0;

   byte_verdict_type awaited_bytes[$];
   int               mismatch_count = 0;
   int               burst_left     = 0;
   stall_mode_type   stall_mode     = STALL_NONE;
   int               mode_cycles    = 0;
   logic [7:0]       ready_pattern  = 8'hff;

   scope_aware_tokenizer_top dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit set_has(logic [63:0] set, int slots, logic [7:0] c);
      for (int i = 0; i < slots && i < 8; i++)
         if (set[8*i +: 8] != 8'h00 && set[8*i +: 8] == c) return 1'b1;
      return 1'b0;
   endfunction

   function automatic byte_verdict_type classify_byte(logic [7:0] c, logic last);
      byte_verdict_type v;
      bit is_delim, is_open, is_close, ends;
      is_delim = set_has(delim_chars, DEFAULT_MAX_DELIMS, c);
      is_open  = set_has({32'd0, open_chars}, DEFAULT_MAX_SCOPE_CHARS, c);
      is_close = set_has({32'd0, close_chars}, DEFAULT_MAX_SCOPE_CHARS, c);
      ends     = 1'b0;
      v.ch     = c;
      v.kind   = KIND_SKIP;
      v.status = STATUS_NONE;
      v.err    = 1'b0;
      if (!string_failed) begin
         if (!in_tok && !is_delim && scope_depth == 0) in_tok = 1'b1;
         if (in_tok && is_delim && scope_depth == 0) begin
            ends = 1'b1;
         end else if (is_open) begin
            if (scope_depth < DEPTH_LIMIT) scope_depth++;
         end else if (is_close) begin
            if (scope_depth == 0) begin
               v.err = 1'b1;
               string_failed = 1'b1;
            end else begin
               scope_depth--;
            end
         end
         if (v.err) begin
            v.kind = KIND_SKIP;
         end else if (ends) begin
            v.kind = KIND_END;
            in_tok = 1'b0;
         end else begin
            v.kind = in_tok ? KIND_TOKEN : KIND_SKIP;
         end
      end
      if (last) begin
         if (string_failed || (!in_tok && scope_depth != 0)) v.status = STATUS_ERROR;
         else v.status = STATUS_CLEAN;
         in_tok        = 1'b0;
         scope_depth   = 0;
         string_failed = 1'b0;
      end
      return v;
   endfunction

   function automatic logic [63:0] pack_set(string s);
      logic [63:0] set;
      set = '0;
      for (int i = 0; i < s.len() && i < 8; i++) set[8*i +: 8] = s[i];
      return set;
   endfunction

   function automatic logic [7:0] pick_slot(logic [63:0] set, int slots);
      logic [7:0] found[$];
      for (int i = 0; i < slots; i++)
         if (set[8*i +: 8] != 8'h00) found.push_back(set[8*i +: 8]);
      if (found.size() == 0) return 8'h00;
      return found[$urandom_range(0, found.size() - 1)];
   endfunction

   function automatic logic [7:0] pick_letter();
      return 8'h61 + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [63:0] random_set(int slots);
      string punct;
      logic [63:0] set;
      punct = " ,;:.|()[]{}<>";
      set = '0;
      for (int i = 0; i < slots; i++) begin
         case ($urandom_range(0, 7))
            0, 1: set[8*i +: 8] = 8'h00;
            2:    set[8*i +: 8] = 8'($urandom_range(1, 255));
            default: set[8*i +: 8] = punct[$urandom_range(0, punct.len() - 1)];
         endcase
      end
      return set;
   endfunction

   task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] exp);
      $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, exp);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      byte_verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_bytes.size() == 0) begin
            flag_mismatch("unexpected item", 64'(rsp_byte_out), 64'd0);
         end else begin
            want = awaited_bytes.pop_front();
            if (rsp_byte_out !== want.ch)
               flag_mismatch("byte_out", 64'(rsp_byte_out), 64'(want.ch));
            if (rsp_byte_kind !== want.kind)
               flag_mismatch("byte_kind", 64'(rsp_byte_kind), 64'(want.kind));
            if (rsp_end_status !== want.status)
               flag_mismatch("end_status", 64'(rsp_end_status), 64'(want.status));
            if (rsp_error_now !== want.err)
               flag_mismatch("error_now", 64'(rsp_error_now), 64'(want.err));
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (mode_cycles == 0) begin
         stall_mode    <= stall_mode_type'($urandom_range(0, 3));
         ready_pattern <= 8'($urandom_range(1, 255));
         mode_cycles   <= $urandom_range(20, 80);
      end else begin
         mode_cycles   <= mode_cycles - 1;
         ready_pattern <= {ready_pattern[6:0], ready_pattern[7]};
      end
      case (stall_mode)
         STALL_NONE:    rsp_ready <= 1'b1;
         STALL_RANDOM:  rsp_ready <= 1'($urandom_range(0, 1));
         STALL_SPARSE:  rsp_ready <= ($urandom_range(0, 3) == 0);
         default:       rsp_ready <= ready_pattern[0];
      endcase
   end

   task automatic push_char(input logic [7:0] c, input logic last);
      int gap;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 20);
      end
      req_valid     <= 1'b1;
      req_byte_in   <= c;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      awaited_bytes.push_back(classify_byte(c, last));
      burst_left--;
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_bytes.size() != 0);
   endtask

   task automatic write_reg(csr_index_type idx, logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // scope registers get junk above bit 31, which must be ignored
   task automatic load_sets(logic [63:0] delims, logic [31:0] opens, logic [31:0] closes);
      drain_results();
      write_reg(CSR_DELIMITER_SET, delims);
      write_reg(CSR_OPEN_SCOPE_SET, {32'($urandom()), opens});
      write_reg(CSR_CLOSE_SCOPE_SET, {32'($urandom()), closes});
      csr_write_enable <= 1'b0;
      delim_chars = delims;
      open_chars  = opens;
      close_chars = closes;
   endtask

   task automatic test_reset_defaults();
      push_text(" ab  c");
      push_char(8'h01, 1'b0);
      push_char(8'hff, 1'b0);
      push_char(8'h20, 1'b1);
   endtask

   task automatic test_scope_nesting();
      load_sets(pack_set(" ,"), 32'(pack_set("([")), 32'(pack_set(")]")));
      push_text(" a( b)c,)xy");
      push_text("[a]");
      push_text("z");
      push_text("(a");
      push_char(8'h00, 1'b0);
      push_char(8'hff, 1'b1);
   endtask

   task automatic test_overlapping_sets();
      load_sets(pack_set(" ()"), 32'(pack_set("(")), 32'(pack_set(")")));
      push_text("a)");
      push_text("((");
      push_text("(x)");
   endtask

   task automatic test_depth_saturation();
      load_sets(pack_set(" "), 32'(pack_set("(")), 32'(pack_set(")")));
      for (int i = 0; i < DEPTH_LIMIT + 3; i++) push_char("(", 1'b0);
      for (int i = 0; i < DEPTH_LIMIT + 1; i++) push_char(")", 1'b0);
      push_char("z", 1'b1);
   endtask

   task automatic test_random_traffic(int count);
      logic [7:0] text[$];
      logic [7:0] c;
      int sent, len, depth, pick;
      bit well;
      sent = 0;
      while (sent < count) begin
         text.delete();
         well  = $urandom_range(0, 99) < 85;
         len   = well ? $urandom_range(1, 20) : $urandom_range(1, 12);
         depth = 0;
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (!well && pick < 50) c = 8'($urandom_range(1, 255));
            else if (pick < 45) c = 8'h00;
            else if (pick < 65) c = pick_slot(delim_chars, DEFAULT_MAX_DELIMS);
            else if (pick < 80) begin
               c = pick_slot({32'd0, open_chars}, DEFAULT_MAX_SCOPE_CHARS);
               if (c != 8'h00) depth++;
            end else if (pick < 95 && (depth > 0 || !well)) begin
               c = pick_slot({32'd0, close_chars}, DEFAULT_MAX_SCOPE_CHARS);
               if (c != 8'h00 && depth > 0) depth--;
            end else c = 8'h00;
            text.push_back(c == 8'h00 ? pick_letter() : c);
         end
         if (well) begin
            while (depth > 0 && close_chars != '0) begin
               text.push_back(pick_slot({32'd0, close_chars}, DEFAULT_MAX_SCOPE_CHARS));
               depth--;
            end
         end
         foreach (text[i]) push_char(text[i], i == text.size() - 1);
         sent += text.size();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_scope_nesting();
      test_overlapping_sets();
      test_depth_saturation();
      load_sets(pack_set(" ,;\t"), 32'(pack_set("([{<")), 32'(pack_set(")]}>")));
      test_random_traffic(60);
      load_sets('0, '0, '0);
      test_random_traffic(20);
      load_sets('1, '1, '1);
      test_random_traffic(20);
      repeat (3) begin
         load_sets(random_set(8), 32'(random_set(4)), 32'(random_set(4)));
         test_random_traffic(30);
      end
      drain_results();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) $display("scope_aware_tokenizer_top test passed");
      else $display("scope_aware_tokenizer_top test failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("scope_aware_tokenizer_top test failed");
      $finish;
   end

endmodule

[scope_aware_tokenizer_top.f]
hw/rtl/sat_pkg.sv
hw/rtl/sat_match.sv
hw/rtl/sat_step.sv
hw/rtl/scope_aware_tokenizer_top.sv
dv/scope_aware_tokenizer_top_test.sv
